@@ design/mcnpm_pkg.sv @@
// types and constants shared by the midi channel note patch mapper
package mcnpm_pkg;

   localparam int NOTE_DEPTH = 128;
   localparam int CHAN_DEPTH = 16;

   localparam logic [1:0] OP_EVENT      = 2'd0;
   localparam logic [1:0] OP_LOAD_DRUM  = 2'd1;
   localparam logic [1:0] OP_LOAD_PATCH = 2'd2;
   localparam logic [1:0] OP_LOAD_CHAN  = 2'd3;

   localparam logic [2:0] KIND_NOTE_ON   = 3'd0;
   localparam logic [2:0] KIND_NOTE_OFF  = 3'd1;
   localparam logic [2:0] KIND_POLY_PRES = 3'd2;
   localparam logic [2:0] KIND_PROGRAM   = 3'd3;

   localparam logic [1:0] FILT_NONE    = 2'd0;
   localparam logic [1:0] FILT_EXTRACT = 2'd1;
   localparam logic [1:0] FILT_REJECT  = 2'd2;

   localparam logic [1:0] CSR_GM_DRUM   = 2'd0;
   localparam logic [1:0] CSR_DEV_DRUM  = 2'd1;
   localparam logic [1:0] CSR_FILT_MODE = 2'd2;
   localparam logic [1:0] CSR_FILT_CHAN = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] kind;
      logic [3:0] channel;
      logic [6:0] data1;
      logic [6:0] data2;
      logic [6:0] map_key;
      logic [6:0] map_value;
      logic       map_valid;
   } req_type;

   typedef struct packed {
      logic [2:0] out_kind;
      logic [3:0] out_channel;
      logic [6:0] out_data1;
      logic [6:0] out_data2;
   } rsp_type;

endpackage

@@ design/mcnpm_ram.sv @@
// generic single write port ram with registered read
module mcnpm_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/midi_channel_note_patch_mapper_top.sv @@
// midi channel filter and channel, drum note and patch remapper, top level
// an event word passes the input stage, then the result register, before it appears on rsp
// throughput: one word per cycle unless a pending result stalls on rsp_ready; loads take effect for the very next word
// the registered drum and patch table reads line up with the input stage, the first of the two stages
// reset: synchronous; all tables invalid, drum channels unset, no filtering
module midi_channel_note_patch_mapper_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mcnpm_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mcnpm_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata
);

   logic [4:0] gm_drum_ff;
   logic [4:0] dev_drum_ff;
   logic [1:0] filt_mode_ff;
   logic [3:0] filt_chan_ff;

   logic [mcnpm_pkg::NOTE_DEPTH-1:0] drum_vld_ff;
   logic [mcnpm_pkg::NOTE_DEPTH-1:0] patch_vld_ff;
   logic [mcnpm_pkg::CHAN_DEPTH-1:0] chan_vld_ff;
   logic [3:0]                       chan_val_ff [mcnpm_pkg::CHAN_DEPTH];

   logic               s1_valid_ff;
   mcnpm_pkg::req_type s1_ff;
   logic               drum_hit_ff;
   logic               patch_hit_ff;
   logic               rsp_valid_ff;
   mcnpm_pkg::rsp_type rsp_ff;
   mcnpm_pkg::rsp_type rsp_in;

   logic       req_acc;
   logic       ev_acc;
   logic       s1_adv;
   logic       s1_drop;
   logic       dev_set;
   logic       gm_set;
   logic [6:0] drum_rd;
   logic [6:0] patch_rd;
   logic [3:0] chan_in;
   logic [6:0] data1_in;

   assign req_acc   = req_valid && req_ready;
   assign ev_acc    = req_acc && (req_payload.op == mcnpm_pkg::OP_EVENT);
   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign dev_set   = !dev_drum_ff[4];
   assign gm_set    = !gm_drum_ff[4];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gm_drum_ff   <= 5'h1f;
         dev_drum_ff  <= 5'h1f;
         filt_mode_ff <= mcnpm_pkg::FILT_NONE;
         filt_chan_ff <= 4'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            mcnpm_pkg::CSR_GM_DRUM:   gm_drum_ff   <= csr_wdata;
            mcnpm_pkg::CSR_DEV_DRUM:  dev_drum_ff  <= csr_wdata;
            mcnpm_pkg::CSR_FILT_MODE: filt_mode_ff <= csr_wdata[1:0];
            mcnpm_pkg::CSR_FILT_CHAN: filt_chan_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // table valid bits and channel table
   always_ff @(posedge clock) begin
      if (reset) begin
         drum_vld_ff  <= '0;
         patch_vld_ff <= '0;
         chan_vld_ff  <= '0;
      end else if (req_acc) begin
         unique case (req_payload.op)
            mcnpm_pkg::OP_LOAD_DRUM:
               drum_vld_ff[req_payload.map_key] <= req_payload.map_valid;
            mcnpm_pkg::OP_LOAD_PATCH:
               patch_vld_ff[req_payload.map_key] <= req_payload.map_valid;
            mcnpm_pkg::OP_LOAD_CHAN:
               chan_vld_ff[req_payload.map_key[3:0]] <= req_payload.map_valid;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req_payload.op == mcnpm_pkg::OP_LOAD_CHAN)) begin
         chan_val_ff[req_payload.map_key[3:0]] <= req_payload.map_value[3:0];
      end
   end

   mcnpm_ram #(
      .WIDTH (7),
      .DEPTH (mcnpm_pkg::NOTE_DEPTH)
   ) u_drum_ram (
      .clock   (clock),
      .wr_en   (req_acc && (req_payload.op == mcnpm_pkg::OP_LOAD_DRUM)),
      .wr_addr (req_payload.map_key),
      .wr_data (req_payload.map_value),
      .rd_en   (ev_acc),
      .rd_addr (req_payload.data1),
      .rd_data (drum_rd)
   );

   mcnpm_ram #(
      .WIDTH (7),
      .DEPTH (mcnpm_pkg::NOTE_DEPTH)
   ) u_patch_ram (
      .clock   (clock),
      .wr_en   (req_acc && (req_payload.op == mcnpm_pkg::OP_LOAD_PATCH)),
      .wr_addr (req_payload.map_key),
      .wr_data (req_payload.map_value),
      .rd_en   (ev_acc),
      .rd_addr (req_payload.data1),
      .rd_data (patch_rd)
   );

   // input stage: event word plus sampled table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= ev_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_acc) begin
         s1_ff        <= req_payload;
         drum_hit_ff  <= drum_vld_ff[req_payload.data1];
         patch_hit_ff <= patch_vld_ff[req_payload.data1];
      end
   end

   // channel filter
   always_comb begin
      case (filt_mode_ff)
         mcnpm_pkg::FILT_EXTRACT: s1_drop = (s1_ff.channel != filt_chan_ff);
         mcnpm_pkg::FILT_REJECT:  s1_drop = (s1_ff.channel == filt_chan_ff);
         default:                 s1_drop = 1'b0;
      endcase
   end

   // channel and data remap
   always_comb begin
      if (gm_set && dev_set && (s1_ff.channel == dev_drum_ff[3:0])) begin
         chan_in = gm_drum_ff[3:0];
      end else if (chan_vld_ff[s1_ff.channel]) begin
         chan_in = chan_val_ff[s1_ff.channel];
      end else begin
         chan_in = s1_ff.channel;
      end

      data1_in = s1_ff.data1;
      case (s1_ff.kind) inside
         mcnpm_pkg::KIND_NOTE_ON, mcnpm_pkg::KIND_NOTE_OFF, mcnpm_pkg::KIND_POLY_PRES: begin
            if (dev_set && (s1_ff.channel == dev_drum_ff[3:0]) && drum_hit_ff) begin
               data1_in = drum_rd;
            end
         end
         mcnpm_pkg::KIND_PROGRAM: begin
            if (patch_hit_ff) begin
               data1_in = patch_rd;
            end
         end
         default: ;
      endcase

      rsp_in.out_kind    = s1_ff.kind;
      rsp_in.out_channel = chan_in;
      rsp_in.out_data1   = data1_in;
      rsp_in.out_data2   = s1_ff.data2;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff && !s1_drop;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_s1_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_ready)
      else $error("input taken while first stage is stalled");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_payload.op != mcnpm_pkg::OP_EVENT)) |=> !s1_valid_ff)
      else $error("load word entered the event stage");

   a_kept_event_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_adv && !s1_drop) |=> rsp_valid_ff)
      else $error("kept event lost before result register");

   a_stalled_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result word overwritten");

endmodule
